@@ hw/rtl/dmns_pkg.sv @@
package dmns_pkg;

	localparam int MULT_BITS   = 32;
	localparam int SHIFT_BITS  = 5;
	localparam int STATUS_BITS = 2;

	typedef enum logic [STATUS_BITS-1:0] {
		STATUS_FOUND = 2'd0,
		STATUS_NONE  = 2'd1,
		STATUS_ZERO  = 2'd2
	} status_t;

endpackage

@@ hw/rtl/dmns_step.sv @@
module dmns_step #(
	parameter int W = 32
) (
	input  logic [W-1:0] rem,
	input  logic         bit_in,
	input  logic [W-1:0] divisor,
	output logic [W-1:0] rem_next,
	output logic         q_bit
);

	logic [W:0] trial;
	logic [W:0] diff;

	assign trial = {rem, bit_in};
	assign diff  = trial - {1'b0, divisor};

	always_comb begin
		if (trial >= {1'b0, divisor}) begin
			q_bit    = 1'b1;
			rem_next = diff[W-1:0];
		end else begin
			q_bit    = 1'b0;
			rem_next = trial[W-1:0];
		end
	end

endmodule

@@ hw/rtl/division_magic_number_search_unit.sv @@
// Channel  | Ports                                  | Handshake
// ---------+----------------------------------------+------------------------------
// in       | divisor                                | start high while busy low
// out      | multiplier, post_shift, status         | done high for one cycle
//
// One shared shift-subtract step runs once per cycle. A transaction first
// divides 2^WORD_BITS + 1 by the divisor (WORD_BITS + 1 steps), then checks
// one shift per cycle, doubling the dividend with each step. done rises as
// the search finds a shift or gives up; a zero divisor reports on the next
// cycle. Reset clears the sequencer and the done strobe. The receiver cannot
// stall; busy falls as done rises, so the next transaction can be taken at
// the edge that ends done.
module division_magic_number_search_unit #(
	parameter int WORD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [dmns_pkg::MULT_BITS-1:0]   divisor,
	output logic                             busy,
	output logic                             done,
	output logic [dmns_pkg::MULT_BITS-1:0]   multiplier,
	output logic [dmns_pkg::SHIFT_BITS-1:0]  post_shift,
	output logic [dmns_pkg::STATUS_BITS-1:0] status
);

	import dmns_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int CW = $clog2(W + 1);
	localparam int LW = $clog2(W);

	typedef enum logic [1:0] {
		IDLE,
		DIV,
		SRCH
	} state_t;

	state_t              state_q;
	logic [W-1:0]        d_q;
	logic [W-1:0]        rem_q;
	logic [W:0]          quo_q;
	logic [W-1:0]        pow_q;
	logic [CW-1:0]       cnt_q;
	logic [LW-1:0]       shift_q;
	logic                done_q;
	logic [W-1:0]        mult_q;
	logic [LW-1:0]       shift_out_q;
	status_t             status_q;

	logic [W-1:0]        dval;
	logic                step_in;
	logic [W-1:0]        step_rem;
	logic                step_bit;

	assign dval    = divisor[W-1:0];
	assign step_in = (state_q == DIV) && ((cnt_q == CW'(W)) || (cnt_q == '0));

	dmns_step #(
		.W(W)
	) u_step (
		.rem      (rem_q),
		.bit_in   (step_in),
		.divisor  (d_q),
		.rem_next (step_rem),
		.q_bit    (step_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			done_q      <= 1'b0;
			d_q         <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			pow_q       <= '0;
			cnt_q       <= '0;
			shift_q     <= '0;
			mult_q      <= '0;
			shift_out_q <= '0;
			status_q    <= STATUS_NONE;
		end else begin
			case (state_q)
				IDLE: begin
					if (start) begin
						d_q     <= dval;
						rem_q   <= '0;
						quo_q   <= '0;
						pow_q   <= W'(1);
						cnt_q   <= CW'(W);
						shift_q <= '0;
						if (dval == '0) begin
							done_q      <= 1'b1;
							mult_q      <= '0;
							shift_out_q <= '0;
							status_q    <= STATUS_ZERO;
						end else begin
							done_q  <= 1'b0;
							state_q <= DIV;
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				DIV: begin
					done_q <= 1'b0;
					rem_q  <= step_rem;
					quo_q  <= {quo_q[W-1:0], step_bit};
					if (cnt_q == '0) begin
						state_q <= SRCH;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				SRCH: begin
					if (quo_q[W] || (rem_q > pow_q && shift_q == LW'(W - 1))) begin
						state_q     <= IDLE;
						done_q      <= 1'b1;
						mult_q      <= '0;
						shift_out_q <= '0;
						status_q    <= STATUS_NONE;
					end else if (rem_q <= pow_q) begin
						state_q     <= IDLE;
						done_q      <= 1'b1;
						mult_q      <= quo_q[W-1:0];
						shift_out_q <= shift_q;
						status_q    <= STATUS_FOUND;
					end else begin
						done_q  <= 1'b0;
						rem_q   <= step_rem;
						quo_q   <= {quo_q[W-1:0], step_bit};
						pow_q   <= {pow_q[W-2:0], 1'b0};
						shift_q <= shift_q + LW'(1);
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != IDLE);
	assign done       = done_q;
	assign multiplier = MULT_BITS'(mult_q);
	assign post_shift = SHIFT_BITS'(shift_out_q);
	assign status     = status_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STATUS_FOUND) |-> (multiplier == '0 && post_shift == '0))
		else $error("nonzero payload on failed search");

	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && divisor[W-1:0] == '0) |=> (done && status == STATUS_ZERO))
		else $error("zero divisor not reported next cycle");

	a_pow_hot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SRCH) |-> $onehot(pow_q))
		else $error("shift weight lost its single bit");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

	import dmns_pkg::*;

	typedef struct {
		logic [MULT_BITS-1:0]  divisor;
		logic [MULT_BITS-1:0]  mult;
		logic [SHIFT_BITS-1:0] shift;
		status_t               st;
	} magic_t;

	localparam int RANDOM_ITEMS = 1400;
	localparam int DRAIN_CYCLES = 80;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic [MULT_BITS-1:0]   divisor = '0;
	logic                   busy;
	logic                   done;
	logic [MULT_BITS-1:0]   multiplier;
	logic [SHIFT_BITS-1:0]  post_shift;
	logic [STATUS_BITS-1:0] status;

	logic [MULT_BITS-1:0] divisor_backlog [$];
	magic_t               expected_magic [$];

	int idle_left = 0;
	int calm_left = 0;
	int errors = 0;
	int n_found = 0;
	int n_none = 0;
	int n_zero = 0;

	logic [MULT_BITS-1:0] corner_divisors [$] = '{
		32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
		32'h0000_0005, 32'h0000_0006, 32'h0000_0007, 32'h0000_000A,
		32'h0000_0281, 32'h0000_03E8, 32'h0000_0004, 32'h0001_0000,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hAAAA_AAAA,
		32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0000,
		32'h0000_0001
	};

	division_magic_number_search_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.divisor    (divisor),
		.busy       (busy),
		.done       (done),
		.multiplier (multiplier),
		.post_shift (post_shift),
		.status     (status)
	);

	always #4 clk = ~clk;

	function automatic magic_t find_magic(logic [MULT_BITS-1:0] d);
		magic_t      r;
		logic [63:0] p;
		logic [63:0] m;
		logic [63:0] wide_d;
		r.divisor = d;
		r.mult = '0;
		r.shift = '0;
		r.st = STATUS_NONE;
		wide_d = {32'd0, d};
		if (d == '0) begin
			r.st = STATUS_ZERO;
		end else begin
			for (int l = 0; l < MULT_BITS; l++) begin
				p = 64'd1 << (MULT_BITS + l);
				m = (p + (64'd1 << l)) / wide_d;
				if (r.st != STATUS_FOUND && m <= 64'h0000_0000_FFFF_FFFF
						&& m * wide_d >= p) begin
					r.mult = m[MULT_BITS-1:0];
					r.shift = SHIFT_BITS'(l);
					r.st = STATUS_FOUND;
				end
			end
		end
		return r;
	endfunction

	function automatic logic [MULT_BITS-1:0] random_divisor();
		logic [MULT_BITS-1:0] pow;
		pow = 32'd1 << $urandom_range(0, 31);
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3, 4:    return $urandom >> $urandom_range(1, 31);
			5:       return $urandom_range(1, 1000);
			6:       return pow;
			7:       return $urandom_range(0, 1) ? pow + 1 : pow - 1;
			8:       return $urandom_range(0, 3);
			default: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
		endcase
	endfunction

	function automatic int pick_idle();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 4);
		if (roll < 97)
			return $urandom_range(5, 40);
		return $urandom_range(60, 150);
	endfunction

	// driver: hold start until the transaction is taken, then idle or advance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			divisor <= '0;
			idle_left = 0;
		end else if (start && !busy) begin
			expected_magic.insert(expected_magic.size(), find_magic(divisor));
			if (calm_left > 0) begin
				calm_left--;
				idle_left = 0;
			end else if ($urandom_range(0, 40) == 0) begin
				calm_left = $urandom_range(20, 60);
				idle_left = 0;
			end else begin
				idle_left = pick_idle();
			end
			if (idle_left == 0 && divisor_backlog.size() != 0) begin
				start <= 1'b1;
				divisor <= divisor_backlog.pop_front();
			end else begin
				start <= 1'b0;
				divisor <= $urandom;
			end
		end else if (!start) begin
			if (idle_left > 0) begin
				idle_left--;
				divisor <= $urandom;
			end else if (divisor_backlog.size() != 0) begin
				start <= 1'b1;
				divisor <= divisor_backlog.pop_front();
			end
		end
	end

	// monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		magic_t want;
		if (arst_n && done) begin
			if (expected_magic.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: m=%h l=%0d st=%0d",
						multiplier, post_shift, status);
			end else begin
				want = expected_magic.pop_front();
				case (want.st)
					STATUS_FOUND: n_found++;
					STATUS_NONE:  n_none++;
					default:      n_zero++;
				endcase
				if (multiplier !== want.mult || post_shift !== want.shift
						|| status !== want.st) begin
					errors++;
					if (errors <= 10)
						$display("mismatch d=%h: expected m=%h l=%0d st=%0d, got m=%h l=%0d st=%0d",
							want.divisor, want.mult, want.shift, want.st,
							multiplier, post_shift, status);
				end
			end
		end
	end

	initial begin
		foreach (corner_divisors[i])
			divisor_backlog.insert(divisor_backlog.size(), corner_divisors[i]);
		for (int i = 0; i < RANDOM_ITEMS; i++)
			divisor_backlog.insert(divisor_backlog.size(), random_divisor());
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (divisor_backlog.size() != 0 || start || expected_magic.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d divisors: %0d with a multiplier, %0d with no shift, %0d zero",
			n_found + n_none + n_zero, n_found, n_none, n_zero);
		if (errors == 0 && expected_magic.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, expected_magic.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("timeout with %0d results outstanding", expected_magic.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/dmns_pkg.sv
hw/rtl/dmns_step.sv
hw/rtl/division_magic_number_search_unit.sv
bench/tb.sv
